// ===== hw/rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared types for the ray/sphere intersection unit
// Beat layouts of the ray and hit channels, the register index codes and the
// ray sideband that travels down the pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_MATERIAL   = 3'd4,
    REG_OBJECT_ID  = 3'd5,
    REG_NEAR_LIMIT = 3'd6,
    REG_FAR_LIMIT  = 3'd7
  } cfg_reg_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // one ray beat
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        current_best_t;
  } ray_in_t;

  // one hit beat
  typedef struct packed {
    logic               hit_flag;
    logic [30:0]        hit_t;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [7:0]         hit_material;
    logic [15:0]        hit_object;
    logic               facing_outward;
  } hit_out_t;

  // ray data carried alongside each stage
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [30:0]      best;
  } sb_t;

endpackage

// ===== hw/rtl/ray_sphere_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersection_unit: pipelined fixed-point ray/sphere tester
// Solves a*t^2 - 2*h*t + c = 0 exactly, picks the nearest positive root and
// reports distance, point, normal, material, object id and facing flag.
// ----------------------------------------------------------------------------
// One ray beat is taken every cycle while the pipeline does not hold. The
// pipeline length is set by the digit pipelines: 66 stages of the square root
// of the discriminant, 31 stages of the distance divider and 32 stages of the
// three normal dividers, one result bit per stage, plus the product and
// selection stages around them. The whole pipeline holds while the output beat
// is stalled, so in_stall follows out_stall of a full output register. The user
// must write configuration while no ray is in flight; the block does not enforce it.
module ray_sphere_intersection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rsi_pkg::ray_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rsi_pkg::hit_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SQ_BITS = 66;               // root bits of the discriminant
  localparam int SQ_W    = 134;              // root remainder width
  localparam int DQ      = 31;               // distance quotient bits
  localparam int DV_W    = 96 + FRAC_BITS;   // distance divider width
  localparam int NQ      = 32;               // normal quotient bits
  localparam int NV_W    = 66 + FRAC_BITS;   // normal divider width

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  logic [31:0] cen_r [3];
  logic [30:0] radius_r, near_r, far_r;
  logic [7:0]  mat_r;
  logic [15:0] obj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      radius_r <= 31'd65536;
      mat_r    <= '0;
      obj_r    <= '0;
      near_r   <= '0;
      far_r    <= 31'h7FFFFFFF;
    end else if (cfg_we) begin
      case (rsi_pkg::cfg_reg_t'(cfg_addr))
        rsi_pkg::REG_CENTER_X:   cen_r[0] <= cfg_wdata;
        rsi_pkg::REG_CENTER_Y:   cen_r[1] <= cfg_wdata;
        rsi_pkg::REG_CENTER_Z:   cen_r[2] <= cfg_wdata;
        rsi_pkg::REG_RADIUS:     radius_r <= cfg_wdata[30:0];
        rsi_pkg::REG_MATERIAL:   mat_r    <= cfg_wdata[7:0];
        rsi_pkg::REG_OBJECT_ID:  obj_r    <= cfg_wdata[15:0];
        rsi_pkg::REG_NEAR_LIMIT: near_r   <= cfg_wdata[30:0];
        rsi_pkg::REG_FAR_LIMIT:  far_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline advance: everything holds while the output beat is stalled
  logic              en;
  logic              out_valid_r;
  rsi_pkg::hit_out_t out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // stage A: capture ray, L = center - origin
  logic             a_v_r;
  rsi_pkg::sb_t     a_sb_r;
  logic [32:0]      a_l_r [3];
  logic [2:0][31:0] in_o;

  assign in_o = {in_data.origin_z, in_data.origin_y, in_data.origin_x};

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sb_r.o    <= in_o;
      a_sb_r.d    <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
      a_sb_r.best <= in_data.current_best_t;
      for (int i = 0; i < 3; i++) begin
        a_l_r[i] <= {cen_r[i][31], cen_r[i]} - {in_o[i][31], in_o[i]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage B: component products d*d, L*d, L*L and r*r
  logic         b_v_r;
  rsi_pkg::sb_t b_sb_r;
  logic [63:0]  b_dd_r [3];
  logic [64:0]  b_ld_r [3];
  logic [65:0]  b_ll_r [3];
  logic [61:0]  b_r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sb_r <= a_sb_r;
      b_r2_r <= radius_r * radius_r;
      for (int i = 0; i < 3; i++) begin
        b_dd_r[i] <= $signed(a_sb_r.d[i]) * $signed(a_sb_r.d[i]);
        b_ld_r[i] <= $signed(a_l_r[i]) * $signed(a_sb_r.d[i]);
        b_ll_r[i] <= $signed(a_l_r[i]) * $signed(a_l_r[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage C: a = d.d, h = L.d, c = L.L - r^2; zero direction or radius misses
  logic         c_v_r, c_m_r;
  rsi_pkg::sb_t c_sb_r;
  logic [63:0]  c_a_r;
  logic [66:0]  c_h_r;
  logic [67:0]  c_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sb_r <= b_sb_r;
      c_a_r  <= b_dd_r[0] + b_dd_r[1] + b_dd_r[2];
      c_h_r  <= {{2{b_ld_r[0][64]}}, b_ld_r[0]} + {{2{b_ld_r[1][64]}}, b_ld_r[1]}
              + {{2{b_ld_r[2][64]}}, b_ld_r[2]};
      c_c_r  <= 68'(b_ll_r[0]) + 68'(b_ll_r[1]) + 68'(b_ll_r[2]) - 68'(b_r2_r);
      c_m_r  <= (b_sb_r.d == '0) || (radius_r == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage D: partial products of h^2 and a*|c| on 33-bit halves
  logic         d_v_r, d_m_r, d_cneg_r;
  rsi_pkg::sb_t d_sb_r;
  logic [63:0]  d_a_r;
  logic [66:0]  d_h_r;
  logic [63:0]  d_hh_r, d_ahch_r, d_ahcl_r;
  logic [64:0]  d_hl_r;
  logic [65:0]  d_ll_r, d_alch_r, d_alcl_r;
  logic [66:0]  habs;
  logic [67:0]  cabs;

  assign habs = c_h_r[66] ? (67'd0 - c_h_r) : c_h_r;
  assign cabs = c_c_r[67] ? (68'd0 - c_c_r) : c_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sb_r   <= c_sb_r;
      d_m_r    <= c_m_r;
      d_a_r    <= c_a_r;
      d_h_r    <= c_h_r;
      d_cneg_r <= c_c_r[67];
      d_hh_r   <= habs[64:33] * habs[64:33];
      d_hl_r   <= habs[64:33] * habs[32:0];
      d_ll_r   <= habs[32:0] * habs[32:0];
      d_ahch_r <= c_a_r[63:33] * cabs[65:33];
      d_ahcl_r <= c_a_r[63:33] * cabs[32:0];
      d_alch_r <= c_a_r[32:0] * cabs[65:33];
      d_alcl_r <= c_a_r[32:0] * cabs[32:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage E: assemble h^2 and a*|c|
  logic         e_v_r, e_m_r, e_cneg_r;
  rsi_pkg::sb_t e_sb_r;
  logic [63:0]  e_a_r;
  logic [66:0]  e_h_r;
  logic [130:0] e_h2_r, e_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en) e_v_r <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_sb_r   <= d_sb_r;
      e_m_r    <= d_m_r;
      e_a_r    <= d_a_r;
      e_h_r    <= d_h_r;
      e_cneg_r <= d_cneg_r;
      e_h2_r   <= (131'(d_hh_r) << 66) + (131'(d_hl_r) << 34) + 131'(d_ll_r);
      e_ac_r   <= (131'(d_ahch_r) << 66) + ((131'(d_ahcl_r) + 131'(d_alch_r)) << 33)
                + 131'(d_alcl_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage F + square root: D = h^2 - a*c, then one root bit per stage
  logic [SQ_BITS:0]     sq_v_r, sq_m_r;
  rsi_pkg::sb_t         sq_sb_r   [SQ_BITS+1];
  logic [63:0]          sq_a_r    [SQ_BITS+1];
  logic [66:0]          sq_h_r    [SQ_BITS+1];
  logic [SQ_W-1:0]      sq_rem_r  [SQ_BITS+1];
  logic [SQ_BITS-1:0]   sq_root_r [SQ_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= e_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sb_r[0]   <= e_sb_r;
      sq_a_r[0]    <= e_a_r;
      sq_h_r[0]    <= e_h_r;
      sq_root_r[0] <= '0;
      sq_m_r[0]    <= e_m_r || (!e_cneg_r && (e_h2_r < e_ac_r));
      sq_rem_r[0]  <= e_cneg_r ? SQ_W'(e_h2_r) + SQ_W'(e_ac_r)
                               : SQ_W'(e_h2_r) - SQ_W'(e_ac_r);
    end
  end

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - k;
    logic [SQ_W-1:0] term;

    // (2*root + 2^B) * 2^B: growth of root^2 when bit B is set
    assign term = (SQ_W'(sq_root_r[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sb_r[k+1] <= sq_sb_r[k];
        sq_m_r[k+1]  <= sq_m_r[k];
        sq_a_r[k+1]  <= sq_a_r[k];
        sq_h_r[k+1]  <= sq_h_r[k];
        if (sq_rem_r[k] >= term) begin
          sq_rem_r[k+1]  <= sq_rem_r[k] - term;
          sq_root_r[k+1] <= sq_root_r[k] | (SQ_BITS'(1) << B);
        end else begin
          sq_rem_r[k+1]  <= sq_rem_r[k];
          sq_root_r[k+1] <= sq_root_r[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage G: root numerator, near root when h - S > 0, else far root
  logic         g_v_r, g_m_r;
  rsi_pkg::sb_t g_sb_r;
  logic [63:0]  g_a_r;
  logic [66:0]  g_n_r;
  logic [67:0]  num_near, num_far, num_sel;

  assign num_near = {sq_h_r[SQ_BITS][66], sq_h_r[SQ_BITS]} - {2'b00, sq_root_r[SQ_BITS]};
  assign num_far  = {sq_h_r[SQ_BITS][66], sq_h_r[SQ_BITS]} + {2'b00, sq_root_r[SQ_BITS]};
  assign num_sel  = (!num_near[67] && (num_near != '0)) ? num_near : num_far;

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (en) g_v_r <= sq_v_r[SQ_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_sb_r <= sq_sb_r[SQ_BITS];
      g_a_r  <= sq_a_r[SQ_BITS];
      g_n_r  <= num_sel[66:0];
      g_m_r  <= sq_m_r[SQ_BITS] || num_sel[67] || (num_sel == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage H + distance divider: t = N * 2^F / a, one bit per stage
  logic [DQ:0]     dv_v_r, dv_m_r;
  rsi_pkg::sb_t    dv_sb_r  [DQ+1];
  logic [63:0]     dv_a_r   [DQ+1];
  logic [DV_W-1:0] dv_rem_r [DQ+1];
  logic [DQ-1:0]   dv_q_r   [DQ+1];
  logic [DV_W-1:0] dv_num;

  assign dv_num = DV_W'(g_n_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= g_v_r;
  end

  // a quotient of 2^31 or more lies beyond any far limit
  always_ff @(posedge clk) begin
    if (en) begin
      dv_sb_r[0]  <= g_sb_r;
      dv_a_r[0]   <= g_a_r;
      dv_rem_r[0] <= dv_num;
      dv_q_r[0]   <= '0;
      dv_m_r[0]   <= g_m_r || (dv_num >= (DV_W'(g_a_r) << DQ));
    end
  end

  for (genvar k = 0; k < DQ; k++) begin : g_tdiv
    localparam int B = DQ - 1 - k;
    logic [DV_W-1:0] den;

    assign den = DV_W'(dv_a_r[k]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= dv_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sb_r[k+1] <= dv_sb_r[k];
        dv_m_r[k+1]  <= dv_m_r[k];
        dv_a_r[k+1]  <= dv_a_r[k];
        if (dv_rem_r[k] >= den) begin
          dv_rem_r[k+1] <= dv_rem_r[k] - den;
          dv_q_r[k+1]   <= dv_q_r[k] | (DQ'(1) << B);
        end else begin
          dv_rem_r[k+1] <= dv_rem_r[k];
          dv_q_r[k+1]   <= dv_q_r[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage W: distance window and |d| * t
  logic         w_v_r, w_m_r;
  rsi_pkg::sb_t w_sb_r;
  logic [30:0]  w_t_r;
  logic [62:0]  w_pr_r [3];
  logic [30:0]  t_q;

  assign t_q = dv_q_r[DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) w_v_r <= 1'b0;
    else if (en) w_v_r <= dv_v_r[DQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_sb_r <= dv_sb_r[DQ];
      w_t_r  <= t_q;
      w_m_r  <= dv_m_r[DQ] || (t_q > dv_sb_r[DQ].best) || (t_q < near_r)
              || (t_q > far_r);
      for (int i = 0; i < 3; i++) begin
        w_pr_r[i] <= mag32(dv_sb_r[DQ].d[i]) * t_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage P: point p = o + d*t, rounded toward minus infinity
  logic         p_v_r, p_m_r;
  rsi_pkg::sb_t p_sb_r;
  logic [30:0]  p_t_r;
  logic [63:0]  p_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (en) p_v_r <= w_v_r;
  end

  always_ff @(posedge clk) begin
    logic [63:0] up;
    logic [63:0] step;
    if (en) begin
      p_sb_r <= w_sb_r;
      p_m_r  <= w_m_r;
      p_t_r  <= w_t_r;
      for (int i = 0; i < 3; i++) begin
        if (w_sb_r.d[i][31]) begin
          up   = 64'(w_pr_r[i]) + ((64'd1 << FRAC_BITS) - 64'd1);
          step = 64'd0 - (up >> FRAC_BITS);
        end else begin
          step = 64'(w_pr_r[i]) >> FRAC_BITS;
        end
        p_p_r[i] <= {{32{w_sb_r.o[i][31]}}, w_sb_r.o[i]} + step;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage Q + normal dividers: |p - center| * 2^F / r in three lanes
  logic [NQ:0]     nd_v_r, nd_m_r;
  rsi_pkg::sb_t    nd_sb_r  [NQ+1];
  logic [30:0]     nd_t_r   [NQ+1];
  logic [31:0]     nd_ps_r  [NQ+1][3];
  logic [NV_W-1:0] nd_rem_r [NQ+1][3];
  logic [NQ-1:0]   nd_q_r   [NQ+1][3];
  logic [2:0]      nd_neg_r [NQ+1];
  logic [2:0]      nd_sat_r [NQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) nd_v_r[0] <= 1'b0;
    else if (en) nd_v_r[0] <= p_v_r;
  end

  always_ff @(posedge clk) begin
    logic [64:0]     off;
    logic [64:0]     offm;
    logic [NV_W-1:0] m;
    if (en) begin
      nd_sb_r[0] <= p_sb_r;
      nd_m_r[0]  <= p_m_r;
      nd_t_r[0]  <= p_t_r;
      for (int i = 0; i < 3; i++) begin
        off  = {p_p_r[i][63], p_p_r[i]} - {{33{cen_r[i][31]}}, cen_r[i]};
        offm = off[64] ? (65'd0 - off) : off;
        m    = NV_W'(offm) << FRAC_BITS;
        nd_neg_r[0][i] <= off[64];
        nd_sat_r[0][i] <= m >= (NV_W'(radius_r) << NQ);
        nd_rem_r[0][i] <= m;
        nd_q_r[0][i]   <= '0;
        // point saturates to 32 bits
        if (p_p_r[i][63:31] == '0 || p_p_r[i][63:31] == '1) nd_ps_r[0][i] <= p_p_r[i][31:0];
        else if (p_p_r[i][63]) nd_ps_r[0][i] <= 32'h80000000;
        else nd_ps_r[0][i] <= 32'h7FFFFFFF;
      end
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_ndiv
    localparam int B = NQ - 1 - k;
    logic [NV_W-1:0] den;

    assign den = NV_W'(radius_r) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) nd_v_r[k+1] <= 1'b0;
      else if (en) nd_v_r[k+1] <= nd_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd_sb_r[k+1]  <= nd_sb_r[k];
        nd_m_r[k+1]   <= nd_m_r[k];
        nd_t_r[k+1]   <= nd_t_r[k];
        nd_neg_r[k+1] <= nd_neg_r[k];
        nd_sat_r[k+1] <= nd_sat_r[k];
        for (int i = 0; i < 3; i++) begin
          nd_ps_r[k+1][i] <= nd_ps_r[k][i];
          if (nd_rem_r[k][i] >= den) begin
            nd_rem_r[k+1][i] <= nd_rem_r[k][i] - den;
            nd_q_r[k+1][i]   <= nd_q_r[k][i] | (NQ'(1) << B);
          end else begin
            nd_rem_r[k+1][i] <= nd_rem_r[k][i];
            nd_q_r[k+1][i]   <= nd_q_r[k][i];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage R: signed normal, rounded toward minus infinity for negative offsets, clamp to 32 bits
  logic         r_v_r, r_m_r;
  rsi_pkg::sb_t r_sb_r;
  logic [30:0]  r_t_r;
  logic [31:0]  r_ps_r [3];
  logic [31:0]  r_n_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else if (en) r_v_r <= nd_v_r[NQ];
  end

  always_ff @(posedge clk) begin
    logic [32:0] qc;
    if (en) begin
      r_sb_r <= nd_sb_r[NQ];
      r_m_r  <= nd_m_r[NQ];
      r_t_r  <= nd_t_r[NQ];
      for (int i = 0; i < 3; i++) begin
        r_ps_r[i] <= nd_ps_r[NQ][i];
        if (nd_neg_r[NQ][i]) begin
          qc = {1'b0, nd_q_r[NQ][i]} + 33'(nd_rem_r[NQ][i] != '0);
          if (nd_sat_r[NQ][i] || qc > 33'h080000000) qc = 33'h080000000;
          r_n_r[i] <= 32'(33'd0 - qc);
        end else if (nd_sat_r[NQ][i] || nd_q_r[NQ][i][31]) begin
          r_n_r[i] <= 32'h7FFFFFFF;
        end else begin
          r_n_r[i] <= nd_q_r[NQ][i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage S: products of d . n for the facing test
  logic         s_v_r, s_m_r;
  rsi_pkg::sb_t s_sb_r;
  logic [30:0]  s_t_r;
  logic [31:0]  s_ps_r [3];
  logic [31:0]  s_n_r  [3];
  logic [63:0]  s_fp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (en) s_v_r <= r_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sb_r <= r_sb_r;
      s_m_r  <= r_m_r;
      s_t_r  <= r_t_r;
      for (int i = 0; i < 3; i++) begin
        s_ps_r[i] <= r_ps_r[i];
        s_n_r[i]  <= r_n_r[i];
        s_fp_r[i] <= $signed(r_sb_r.d[i]) * $signed(r_n_r[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: a miss clears every field
  logic [65:0] dot;

  assign dot = {{2{s_fp_r[0][63]}}, s_fp_r[0]} + {{2{s_fp_r[1][63]}}, s_fp_r[1]}
             + {{2{s_fp_r[2][63]}}, s_fp_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_m_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r.hit_flag       <= 1'b1;
        out_data_r.hit_t          <= s_t_r;
        out_data_r.point_x        <= s_ps_r[0];
        out_data_r.point_y        <= s_ps_r[1];
        out_data_r.point_z        <= s_ps_r[2];
        out_data_r.normal_x       <= s_n_r[0];
        out_data_r.normal_y       <= s_n_r[1];
        out_data_r.normal_z       <= s_n_r[2];
        out_data_r.hit_material   <= mat_r;
        out_data_r.hit_object     <= obj_r;
        out_data_r.facing_outward <= dot[65];
      end
    end
  end

endmodule

// ===== hw/rtl/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for the ray/sphere intersection unit
// Watches the two beat channels and is bound to the top level below.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rsi_pkg::hit_out_t out_data
);

  // a held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // the ray side only stalls behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit_flag |-> out_data == '0)
    else $error("miss beat with nonzero fields");

  // no beat appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ray_sphere_intersection_unit rsi_checker u_rsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
